>>> rtl/sfq_pkg.sv
// Shared types, sizes and conversion functions for the sortable queue.
package sfq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_SORT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SORT = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_item_t;

  // Sequencer to cell row
  typedef struct packed {
    logic load;
    logic shift;
    logic sort_en;
    logic phase;
    cnt_t count;
  } seq_ctl_t;

  // Per-cell controls
  typedef struct packed {
    logic load;
    logic shift;
    logic pair_lo;
    logic pair_hi;
  } cell_ctl_t;

  // Sign-extend the 32-bit input, keep the low word bits.
  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word, keep the low 32 bits for the result port.
  function automatic logic signed [31:0] to_out(word_t w);
    logic signed [63:0] ext;
    ext = 64'($signed(w));
    return ext[31:0];
  endfunction

endpackage

>>> rtl/sfq_cell.sv
// One storage cell of the queue row: load, shift forward, compare-exchange.
module sfq_cell
  import sfq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl_i,
  input  word_t     wr_data_i,
  input  word_t     left_i,
  input  word_t     right_i,
  input  logic      gt_left_i,
  output word_t     data_o,
  output logic      gt_o
);

  word_t data_r;
  word_t data_nxt;

  assign gt_o   = $signed(data_r) > $signed(right_i);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.load) begin
      data_nxt = wr_data_i;
    end else if (ctl_i.shift) begin
      data_nxt = right_i;
    end else if (ctl_i.pair_lo && gt_o) begin
      // lower slot of a pair keeps the minimum
      data_nxt = right_i;
    end else if (ctl_i.pair_hi && gt_left_i) begin
      data_nxt = left_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> rtl/sfq_ctrl.sv
// Command sequencer: fill count, sort rounds and the result register.
module sfq_ctrl
  import sfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  input  word_t     front_i,
  output logic      busy,
  output seq_ctl_t  ctl_o,
  output logic      out_valid,
  output out_item_t out_item
);

  state_t    state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  cnt_t      rnd_r, rnd_nxt;
  logic      phase_r, phase_nxt;
  logic      ov_r, ov_nxt;
  out_item_t oi_r, oi_nxt;
  logic      accept;

  localparam cnt_t FULL_CNT = CNT_W'(DEPTH);

  assign busy      = (state_r == S_SORT);
  assign accept    = start && (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rnd_nxt       = rnd_r;
    phase_nxt     = phase_r;
    ov_nxt        = 1'b0;
    oi_nxt        = oi_r;
    ctl_o         = '0;
    ctl_o.count   = count_r;
    ctl_o.phase   = phase_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          oi_nxt.out_value = '0;
          oi_nxt.status    = ST_OK;
          ov_nxt           = 1'b1;
          unique case (cmd_t'(in_item.cmd))
            CMD_ENQ: begin
              if (count_r == FULL_CNT) begin
                oi_nxt.status = ST_FULL;
              end else begin
                ctl_o.load = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            CMD_DEQ: begin
              if (count_r == '0) begin
                oi_nxt.status = ST_EMPTY;
              end else begin
                ctl_o.shift      = 1'b1;
                oi_nxt.out_value = to_out(front_i);
                count_nxt        = count_r - 1'b1;
              end
            end
            CMD_SORT: begin
              ov_nxt    = 1'b0;
              state_nxt = S_SORT;
              rnd_nxt   = count_r;
              phase_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          oi_nxt.occupancy = 5'(count_nxt);
        end
      end
      S_SORT: begin
        ctl_o.sort_en = 1'b1;
        phase_nxt     = ~phase_r;
        rnd_nxt       = rnd_r - 1'b1;
        if (rnd_r < CNT_W'(2)) begin
          state_nxt        = S_IDLE;
          ov_nxt           = 1'b1;
          oi_nxt.out_value = '0;
          oi_nxt.status    = ST_OK;
          oi_nxt.occupancy = 5'(count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rnd_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      rnd_r   <= rnd_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
  end

endmodule

>>> rtl/sortable_fifo_queue.sv
// Top level of the sortable queue: sequencer and the row of storage cells.
//
// Usage: drive in_item and raise start; a command transfers at a rising edge
// where start is high and busy is low. Every command produces exactly one
// result, shown on out_item for a single cycle with out_valid high; the
// receiver takes it at that edge and cannot hold it off.
// Enqueue, dequeue and the unused command code complete without a busy phase:
// the result appears the cycle after the transfer, and busy stays low, so these
// commands can transfer on every cycle.
// Sort runs odd-even transposition rounds over the cell row, one round per
// cycle, as many rounds as there are stored entries (at least one). busy is
// high while the rounds run and the result follows the last round.
// Reset (rst_n low, synchronous) empties the queue and drops any result or
// sort in flight; stored words are not cleared, only the fill count.
module sortable_fifo_queue
  import sfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  seq_ctl_t seq_ctl;
  word_t    cell_data [DEPTH];
  logic     cell_gt   [DEPTH];
  word_t    wr_word;

  // Convert the enqueue value to storage width once, for every cell.
  assign wr_word = to_word(in_item.item_value);

  sfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .front_i   (cell_data[0]),
    .busy      (busy),
    .ctl_o     (seq_ctl),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Cell k holds queue position k; position 0 is the front.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic PAR_LO = 1'(k % 2);
    localparam logic PAR_HI = 1'((k + 1) % 2);

    cell_ctl_t cctl;
    word_t     left_w;
    word_t     right_w;
    logic      gt_left_w;

    if (k == 0) begin : g_front
      assign left_w    = cell_data[k];
      assign gt_left_w = 1'b0;
    end else begin : g_mid_l
      assign left_w    = cell_data[k-1];
      assign gt_left_w = cell_gt[k-1];
    end

    // The back cell shifts in its own word; it lies beyond the fill count.
    if (k == DEPTH - 1) begin : g_back
      assign right_w = cell_data[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end

    always_comb begin
      cctl.load    = seq_ctl.load && (seq_ctl.count == CNT_W'(k));
      cctl.shift   = seq_ctl.shift;
      // Pair (k, k+1) takes part only while both members are stored entries.
      cctl.pair_lo = seq_ctl.sort_en && (k < DEPTH - 1) && (seq_ctl.phase == PAR_LO)
                     && (CNT_W'(k + 1) < seq_ctl.count);
      cctl.pair_hi = seq_ctl.sort_en && (k > 0) && (seq_ctl.phase == PAR_HI)
                     && (CNT_W'(k) < seq_ctl.count);
    end

    sfq_cell u_cell (
      .clk       (clk),
      .ctl_i     (cctl),
      .wr_data_i (wr_word),
      .left_i    (left_w),
      .right_i   (right_w),
      .gt_left_i (gt_left_w),
      .data_o    (cell_data[k]),
      .gt_o      (cell_gt[k])
    );
  end

endmodule

>>> rtl/sfq_checker.sv
// Port-level checks for the sortable queue, bound to the top level.
module sfq_port_checks
  import sfq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.cmd != CMD_SORT) |=> out_valid)
    else $error("enqueue/dequeue transfer without a result next cycle");

  a_sort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.cmd == CMD_SORT) |=> busy && !out_valid)
    else $error("sort transfer did not hold the block busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> out_item.out_value == '0)
    else $error("error result carries a nonzero value");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_EMPTY) |-> out_item.occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |-> out_item.occupancy == 5'(DEPTH))
    else $error("full status with occupancy below depth");

endmodule

bind sortable_fifo_queue sfq_port_checks u_sfq_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> dv/sfq_checker.sv
// Result checker for the sortable queue: shadow storage, prediction and compare.
module sfq_checker
  import sfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        pending,
  output int        failures
);

  word_t     shadow [DEPTH];
  int        shadow_fill;
  out_item_t due_results [$];

  initial begin
    pending     = 0;
    failures    = 0;
    shadow_fill = 0;
  end

  // Apply one command to the shadow queue and return the result it must give.
  function automatic out_item_t run_queue_command(in_item_t item);
    out_item_t          res;
    logic signed [63:0] wide;
    word_t              tmp;
    res        = '0;
    res.status = ST_OK;
    case (item.cmd)
      CMD_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          wide                = $signed(item.item_value);
          shadow[shadow_fill] = wide[DATA_WIDTH-1:0];
          shadow_fill++;
        end
      end
      CMD_DEQ: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          wide          = $signed(shadow[0]);
          res.out_value = wide[31:0];
          for (int k = 1; k < shadow_fill; k++) shadow[k-1] = shadow[k];
          shadow_fill--;
        end
      end
      CMD_SORT: begin
        for (int pass = 1; pass < shadow_fill; pass++) begin
          for (int k = 0; k + pass < shadow_fill; k++) begin
            if ($signed(shadow[k]) > $signed(shadow[k+1])) begin
              tmp         = shadow[k];
              shadow[k]   = shadow[k+1];
              shadow[k+1] = tmp;
            end
          end
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(shadow_fill);
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      due_results.delete();
    end else begin
      // compare first so a stray result is not matched to this edge's transfer
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("out_item: result with nothing outstanding");
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("out_value", want.out_value, out_item.out_value);
          check_field("status", want.status, out_item.status);
          check_field("occupancy", want.occupancy, out_item.occupancy);
        end
      end
      if (start && !busy) due_results.push_back(run_queue_command(in_item));
    end
    pending = due_results.size();
  end

endmodule

>>> dv/testbench.sv
// Top of the sortable queue testbench: clock, reset, command stimulus and verdict.
module testbench;
  import sfq_pkg::*;

  // Unused command code; the block must treat it as a no-op.
  localparam logic [1:0] CMD_NOP      = 2'd3;
  // Longest sort plus the result cycle, with some margin.
  localparam int         LATENCY      = DEPTH + 4;
  localparam int         RANDOM_ITEMS = 1150;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        pending;
  int        failures;
  int        idle_pct;

  sortable_fifo_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  sfq_checker result_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .pending  (pending),
    .failures (failures)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a transfer or a result never arrives.
  initial begin
    #(4_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  // Send one command: idle a random number of cycles first, then hold start
  // high until a rising edge sees busy low, which is the transfer.
  task automatic issue(input logic [1:0] cmd, input logic signed [31:0] value);
    while ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= '{cmd: 2'($urandom), item_value: $urandom};
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= '{cmd: cmd, item_value: value};
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mix extremes and a narrow band (for duplicates in the sort) into the values.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // enq_pct steers the burst toward filling or draining the queue.
  function automatic logic [1:0] pick_cmd(int enq_pct);
    int r;
    r = $urandom_range(1, 100);
    if (r <= 3) return CMD_NOP;
    if (r <= 12) return CMD_SORT;
    if (r <= 12 + (enq_pct * 88) / 100) return CMD_ENQ;
    return CMD_DEQ;
  endfunction

  initial begin
    int sent;
    int burst_len;
    int enq_pct;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty and full corners, single-entry sort, no-op code,
    // and the value extremes with alternating bit patterns.
    issue(CMD_DEQ, 32'sd0);
    issue(CMD_SORT, 32'sd0);
    issue(CMD_ENQ, 32'sh7FFF_FFFF);
    issue(CMD_SORT, 32'sd0);
    issue(CMD_NOP, -32'sd1);
    issue(CMD_ENQ, 32'sh8000_0000);
    issue(CMD_ENQ, -32'sd1);
    issue(CMD_ENQ, 32'sd0);
    issue(CMD_ENQ, 32'sd1);
    issue(CMD_ENQ, 32'sh5555_5555);
    issue(CMD_ENQ, 32'shAAAA_AAAA);
    repeat (DEPTH - 6) issue(CMD_ENQ, pick_value());
    issue(CMD_ENQ, 32'sd12345);
    issue(CMD_SORT, 32'sd0);
    issue(CMD_DEQ, 32'sd0);
    issue(CMD_DEQ, 32'sd0);
    wait_drained();

    // Random part in three phases: moderate idling, heavy idling, none.
    // Bursts lean toward filling or draining so the queue sweeps its range.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 45 : 0;
      sent     = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        burst_len = $urandom_range(4, 32);
        case ($urandom_range(0, 2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
        repeat (burst_len) begin
          issue(pick_cmd(enq_pct), pick_value());
          sent++;
        end
      end
      wait_drained();
    end

    repeat (LATENCY) @(negedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sfq_pkg.sv
rtl/sfq_cell.sv
rtl/sfq_ctrl.sv
rtl/sortable_fifo_queue.sv
rtl/sfq_checker.sv
dv/sfq_checker.sv
dv/testbench.sv
